[hw/rtl/ptwa_pkg.sv]
package ptwa_pkg;

  // sizing
  localparam int MAX_WINDOW = 16;
  localparam int COORD_BITS = 12;
  localparam int IDX_BITS   = $clog2(MAX_WINDOW);
  localparam int CNT_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS   = COORD_BITS + $clog2(MAX_WINDOW);
  localparam int WIN_BITS   = 5;
  localparam int WIN_RESET  = 10;
  localparam int LEN_BITS   = (WIN_BITS > CNT_BITS) ? WIN_BITS + 1 : CNT_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

  // stream packing
  localparam int IN_DATA_BITS   = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + CNT_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [SUM_BITS-1:0]   sum_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [WIN_BITS-1:0]   win_t;

  // input item kind
  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_EMPTY = 1'b1
  } action_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

  // update command into the window store
  typedef struct packed {
    logic    upd;
    action_t action;
    coord_t  pos_x;
    coord_t  pos_y;
  } win_cmd_t;

  // running window status
  typedef struct packed {
    sum_t sum_x;
    sum_t sum_y;
    cnt_t count;
  } win_stat_t;

endpackage

[hw/rtl/ptwa_div.sv]
module ptwa_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ptwa_pkg::sum_t   dividend,
  input  ptwa_pkg::cnt_t   divisor,
  output ptwa_pkg::coord_t quotient,
  output logic             done
);
  import ptwa_pkg::*;

  sum_t                    dvd_r;
  cnt_t                    dsr_r;
  cnt_t                    rem_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic                    busy_r;
  logic                    done_r;

  logic [CNT_BITS:0] rem_sh;
  logic [CNT_BITS:0] rem_sub;
  logic              ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh  = {rem_r, dvd_r[SUM_BITS-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    ge      = (rem_sh >= {1'b0, dsr_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_BITS'(SUM_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_BITS'(1);
        if (cnt_r == DIV_CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out at the top, quotient shifts in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[SUM_BITS-2:0], ge};
      rem_r <= ge ? rem_sub[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
    end
  end

  assign quotient = dvd_r[COORD_BITS-1:0];
  assign done     = done_r;

endmodule

[hw/rtl/ptwa_window.sv]
module ptwa_window (
  input  logic                clk,
  input  logic                rst_n,
  input  ptwa_pkg::win_t      win_len,
  input  ptwa_pkg::win_cmd_t  cmd,
  output ptwa_pkg::win_stat_t stat
);
  import ptwa_pkg::*;

  // ring store, no reset; only live entries are read
  coord_t store_x [MAX_WINDOW];
  coord_t store_y [MAX_WINDOW];

  coord_t rd_x_r;
  coord_t rd_y_r;
  idx_t   oldest_r;
  cnt_t   count_r;
  sum_t   sum_x_r;
  sum_t   sum_y_r;

  logic [LEN_BITS-1:0] len_ext;
  cnt_t                eff_len;
  logic                is_add;
  logic                drop;
  logic [CNT_BITS:0]   slot_sum;
  idx_t                wr_slot;
  idx_t                oldest_inc;
  sum_t                sub_x;
  sum_t                sub_y;
  sum_t                add_x;
  sum_t                add_y;

  // effective window length, clamped to 1..MAX_WINDOW
  always_comb begin
    len_ext = LEN_BITS'(win_len);
    if (len_ext == '0) begin
      eff_len = CNT_BITS'(1);
    end else if (len_ext > LEN_BITS'(MAX_WINDOW)) begin
      eff_len = CNT_BITS'(MAX_WINDOW);
    end else begin
      eff_len = len_ext[CNT_BITS-1:0];
    end
  end

  // drop decision, slots and sum deltas
  always_comb begin
    is_add = (cmd.action == ACT_ADD);
    if (is_add) begin
      drop = (count_r >= eff_len);
    end else begin
      drop = (count_r != '0);
    end
    slot_sum = {1'b0, CNT_BITS'(oldest_r)} + {1'b0, count_r};
    if (slot_sum >= (CNT_BITS + 1)'(MAX_WINDOW)) begin
      slot_sum = slot_sum - (CNT_BITS + 1)'(MAX_WINDOW);
    end
    wr_slot = slot_sum[IDX_BITS-1:0];
    if (oldest_r == IDX_BITS'(MAX_WINDOW - 1)) begin
      oldest_inc = '0;
    end else begin
      oldest_inc = oldest_r + IDX_BITS'(1);
    end
    sub_x = drop ? SUM_BITS'(rd_x_r) : '0;
    sub_y = drop ? SUM_BITS'(rd_y_r) : '0;
    add_x = is_add ? SUM_BITS'(cmd.pos_x) : '0;
    add_y = is_add ? SUM_BITS'(cmd.pos_y) : '0;
  end

  // store write and registered read of the oldest entry
  always_ff @(posedge clk) begin
    if (cmd.upd && is_add) begin
      store_x[wr_slot] <= cmd.pos_x;
      store_y[wr_slot] <= cmd.pos_y;
    end
    rd_x_r <= store_x[oldest_r];
    rd_y_r <= store_y[oldest_r];
  end

  // pointer, count and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
    end else if (cmd.upd) begin
      if (drop) begin
        oldest_r <= oldest_inc;
      end
      count_r <= count_r - CNT_BITS'(drop) + CNT_BITS'(is_add);
      sum_x_r <= sum_x_r - sub_x + add_x;
      sum_y_r <= sum_y_r - sub_y + add_y;
    end
  end

  assign stat.sum_x = sum_x_r;
  assign stat.sum_y = sum_y_r;
  assign stat.count = count_r;

endmodule

[hw/rtl/point_track_window_average.sv]
// channel | dir | signals                         | contents
// in      | in  | in_tvalid/in_tready/in_tdata    | tdata: pos_x, pos_y; tuser: action
// out     | out | out_tvalid/out_tready/out_tdata | tdata: avg_x, avg_y, point_count
// cfg     | in  | cfg_wr_en/cfg_wr_data           | window_length, to be written only when idle (not enforced)
//
// one item goes from acceptance to the next acceptance through: accept, window update,
// divider load, the serial shift of the two side-by-side dividers, divider done, output load
// the serial divider sets the rate; a new item is taken once the previous result
// sits in the output register, even while that result waits for out_tready
// rst_n is synchronous; the ring store itself is not cleared, only pointer,
// count and sums, and window_length returns to 10
module point_track_window_average (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ptwa_pkg::IN_DATA_BITS-1:0]   in_tdata,   // pos_x, pos_y
  input  logic                                in_tuser,   // action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ptwa_pkg::OUT_DATA_BITS-1:0]  out_tdata,  // avg_x, avg_y, point_count
  input  logic                                cfg_wr_en,
  input  ptwa_pkg::win_t                      cfg_wr_data
);
  import ptwa_pkg::*;

  state_t    state_r;
  state_t    state_nxt;
  win_t      win_len_r;
  win_cmd_t  cmd;
  win_stat_t stat;

  action_t   act_r;
  coord_t    pos_x_r;
  coord_t    pos_y_r;

  logic      win_upd;
  logic      div_start;
  coord_t    quo_x;
  coord_t    quo_y;
  logic      done_x;
  logic      done_y;
  logic      out_load;

  logic      out_valid_r;
  logic      out_valid_nxt;
  coord_t    avg_x_r;
  coord_t    avg_y_r;
  cnt_t      count_out_r;

  logic      in_acc;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WIN_BITS'(WIN_RESET);
    end else if (cfg_wr_en) begin
      win_len_r <= cfg_wr_data;
    end
  end

  // input capture
  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= action_t'(in_tuser);
      pos_x_r <= in_tdata[COORD_BITS-1:0];
      pos_y_r <= in_tdata[2*COORD_BITS-1:COORD_BITS];
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: state_nxt = ST_START;
      ST_START:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (done_x) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    win_upd   = 1'b0;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_UPDATE: win_upd   = 1'b1;
      ST_START:  div_start = 1'b1;
      ST_OUT:    out_load  = !out_valid_r || out_tready;
      default:   in_tready = 1'b0;
    endcase
  end

  // update command: upd, action, pos_x, pos_y from the top bit down
  assign cmd = {win_upd, act_r, pos_x_r, pos_y_r};

  // window store and running sums
  ptwa_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .win_len (win_len_r),
    .cmd     (cmd),
    .stat    (stat)
  );

  // one serial divider per coordinate
  ptwa_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (stat.sum_x),
    .divisor  (stat.count),
    .quotient (quo_x),
    .done     (done_x)
  );

  ptwa_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (stat.sum_y),
    .divisor  (stat.count),
    .quotient (quo_y),
    .done     (done_y)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // empty window reports a zero mean
  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_x_r     <= (stat.count == '0) ? '0 : quo_x;
      avg_y_r     <= (stat.count == '0) ? '0 : quo_y;
      count_out_r <= stat.count;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata = '0;
    out_tdata[COORD_BITS-1:0]            = avg_x_r;
    out_tdata[2*COORD_BITS-1:COORD_BITS] = avg_y_r;
    out_tdata[OUT_FIELD_BITS-1:2*COORD_BITS] = count_out_r;
  end

`ifndef SYNTHESIS
  // window never holds more than the store depth
  assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_BITS'(MAX_WINDOW))
    else $error("window count beyond store depth");

  // both dividers finish together and only while dividing
  assert property (@(posedge clk) disable iff (!rst_n)
    (done_x || done_y) |-> (done_x && done_y && state_r == ST_DIV))
    else $error("divider done out of step");

  // an accepted transaction goes straight to the window update
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_UPDATE)
    else $error("accepted transaction not updating window");

  // empty window reports zero means
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && count_out_r == '0) |-> (avg_x_r == '0 && avg_y_r == '0))
    else $error("nonzero mean for empty window");
`endif

endmodule

[sim/point_track_window_average_tb.sv]
module point_track_window_average_tb;
  import ptwa_pkg::*;

  // one expected result of the tracker
  typedef struct {
    coord_t avg_x;
    coord_t avg_y;
    cnt_t   count;
  } track_avg_t;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_tvalid   = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata    = '0;   // pos_x, pos_y
  logic                     in_tuser    = 1'b0; // action
  logic                     out_tvalid;
  logic                     out_tready  = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;          // avg_x, avg_y, point_count
  logic                     cfg_wr_en   = 1'b0;
  win_t                     cfg_wr_data = '0;

  // predicted tracker state
  coord_t trk_x [MAX_WINDOW];
  coord_t trk_y [MAX_WINDOW];
  int     trk_head;
  int     trk_count;
  int     trk_sum_x;
  int     trk_sum_y;
  win_t   trk_win;

  track_avg_t pending_avgs[$];

  int items_sent      = 0;
  int adds_sent       = 0;
  int results_checked = 0;
  int mismatch_count  = 0;
  int window_writes   = 0;
  int burst_left      = 0;
  int full_seen       = 0;

  point_track_window_average i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void track_drop_oldest();
    if (trk_count != 0) begin
      trk_sum_x -= trk_x[trk_head];
      trk_sum_y -= trk_y[trk_head];
      trk_head   = (trk_head + 1) % MAX_WINDOW;
      trk_count--;
    end
  endfunction

  function automatic track_avg_t track_step(action_t act, coord_t x, coord_t y);
    int         lim;
    int         slot;
    track_avg_t r;
    lim = (trk_win == 0) ? 1 : ((trk_win > MAX_WINDOW) ? MAX_WINDOW : int'(trk_win));
    if (act == ACT_ADD) begin
      // full store or window reached: oldest slot is freed first
      if (trk_count + 1 > lim || trk_count >= MAX_WINDOW) track_drop_oldest();
      slot        = (trk_head + trk_count) % MAX_WINDOW;
      trk_x[slot] = x;
      trk_y[slot] = y;
      trk_sum_x  += x;
      trk_sum_y  += y;
      trk_count++;
    end else begin
      track_drop_oldest();
    end
    if (trk_count == MAX_WINDOW) full_seen++;
    // empty store averages to zero
    r.avg_x = (trk_count == 0) ? '0 : coord_t'(trk_sum_x / trk_count);
    r.avg_y = (trk_count == 0) ? '0 : coord_t'(trk_sum_y / trk_count);
    r.count = cnt_t'(trk_count);
    return r;
  endfunction

  // ---------------------------------------------------------------- result check

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      coord_t     got_x;
      coord_t     got_y;
      cnt_t       got_cnt;
      track_avg_t want;
      got_x   = out_tdata[COORD_BITS-1:0];
      got_y   = out_tdata[2*COORD_BITS-1:COORD_BITS];
      got_cnt = out_tdata[2*COORD_BITS+CNT_BITS-1:2*COORD_BITS];
      if (pending_avgs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result transaction avg_x=%0d avg_y=%0d count=%0d",
                   got_x, got_y, got_cnt);
      end else begin
        want = pending_avgs.pop_front();
        results_checked++;
        if (got_x !== want.avg_x || got_y !== want.avg_y || got_cnt !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d expected x=%0d y=%0d n=%0d, got x=%0d y=%0d n=%0d",
                     results_checked, want.avg_x, want.avg_y, want.count,
                     got_x, got_y, got_cnt);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver stalls

  // stall style is redrawn whenever its timer runs out: none, random, long, alternating
  int stall_mode  = 0;
  int stall_timer = 0;
  int stall_tick  = 0;

  always @(negedge clk) begin
    stall_tick++;
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_timer = $urandom_range(50, 300);
    end else begin
      stall_timer--;
    end
    case (stall_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= ($urandom_range(0, 5) == 0);
      end
      default: begin
        out_tready <= stall_tick[1];
      end
    endcase
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
    endcase
  endfunction

  // one input transaction, with bursts and random gaps before it
  task automatic send_item(action_t act, coord_t x, coord_t y);
    int         gap;
    track_avg_t exp_avg;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = '0;
    in_tdata[COORD_BITS-1:0]            = x;
    in_tdata[2*COORD_BITS-1:COORD_BITS] = y;
    do @(posedge clk); while (!in_tready);
    exp_avg = track_step(act, x, y);
    pending_avgs.insert(pending_avgs.size(), exp_avg);
    items_sent++;
    if (act == ACT_ADD) adds_sent++;
  endtask

  // hold off the sender until every result is back and the block is quiet
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_window(win_t len);
    drain();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = len;
    @(posedge clk);
    trk_win = len;
    window_writes++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_store();
    send_item(ACT_EMPTY, '1, '1);
  endtask

  task automatic test_coord_extremes();
    send_item(ACT_ADD, '0, '0);
    send_item(ACT_ADD, '1, '1);
    send_item(ACT_ADD, '1, '0);
    send_item(ACT_ADD, '0, '1);
    send_item(ACT_ADD, 12'hAAA, 12'h555);
    send_item(ACT_EMPTY, 12'h555, 12'hAAA);
    send_item(ACT_EMPTY, '0, '0);
  endtask

  // window below the current count: adds hold the count, empties shrink it
  task automatic test_window_shrink();
    set_window(5'd2);
    send_item(ACT_ADD, 12'd100, 12'd4000);
    send_item(ACT_EMPTY, '0, '0);
    send_item(ACT_ADD, 12'd7, 12'd9);
  endtask

  // zero acts as one, values above the store size saturate
  task automatic test_window_limits();
    set_window(5'd0);
    send_item(ACT_ADD, 12'd1, 12'd2);
    send_item(ACT_EMPTY, '0, '0);
    send_item(ACT_ADD, 12'd4094, 12'd3);
    send_item(ACT_EMPTY, '0, '0);
    send_item(ACT_EMPTY, '0, '0);
    set_window(5'd31);
    send_item(ACT_ADD, '1, '1);
    send_item(ACT_ADD, '1, '0);
  endtask

  task automatic run_random_phase(win_t len, int n, int add_pct);
    action_t act;
    set_window(len);
    repeat (n) begin
      act = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_EMPTY;
      send_item(act, rand_coord(), rand_coord());
    end
  endtask

  task automatic test_random_windows();
    run_random_phase(5'd31, 60, 85);
    run_random_phase(5'd16, 50, 70);
    run_random_phase(5'd3,  40, 75);
    run_random_phase(5'd1,  35, 60);
    run_random_phase(5'd17, 55, 90);
    run_random_phase(5'd5,  45, 50);
    run_random_phase(5'd0,  30, 55);
    run_random_phase(5'd10, 45, 40);
    run_random_phase(5'd8,  45, 70);
    run_random_phase(5'd12, 45, 65);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    trk_head  = 0;
    trk_count = 0;
    trk_sum_x = 0;
    trk_sum_y = 0;
    trk_win   = win_t'(WIN_RESET);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_store();
    test_coord_extremes();
    test_window_shrink();
    test_window_limits();
    test_random_windows();

    drain();
    $display("run covered %0d items (%0d adds, %0d empty events), %0d results checked,",
             items_sent, adds_sent, items_sent - adds_sent, results_checked);
    $display("%0d window writes, full store reached %0d times", window_writes, full_seen);
    if (mismatch_count == 0 && pending_avgs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", pending_avgs.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ptwa_pkg.sv
hw/rtl/ptwa_div.sv
hw/rtl/ptwa_window.sv
hw/rtl/point_track_window_average.sv
sim/point_track_window_average_tb.sv
